[rtl/mwm_pkg.sv]
// Shared types, widths and constants for the mecanum wheel mixer.
// Used by every module of the mixer; depends on nothing else.
`default_nettype none

package mwm_pkg;

    // Field and datapath widths.
    localparam int unsigned CMD_W      = 8;
    localparam int unsigned NUM_WHEELS = 4;
    localparam int unsigned SUM_W      = 10;  // three 8-bit terms, -384..383
    localparam int unsigned MAG_W      = 9;   // magnitude of a sum, 0..384
    localparam int unsigned LIM_W      = 7;   // clamped limit, 0..100
    localparam int unsigned PROD_W     = MAG_W + LIM_W;
    localparam int unsigned QUO_W      = 7;   // quotient never exceeds the limit

    // Full duty scale, also the smallest divisor.
    localparam int unsigned FULL_SCALE = 100;

    // Wheel lane order.
    localparam int unsigned WHEEL_FL = 0;
    localparam int unsigned WHEEL_FR = 1;
    localparam int unsigned WHEEL_RL = 2;
    localparam int unsigned WHEEL_RR = 3;

    // Magnitudes and signs of the four wheel sums with the common divisor.
    typedef struct packed {
        logic [NUM_WHEELS-1:0]             neg;
        logic [NUM_WHEELS-1:0][MAG_W-1:0]  mag;
        logic [MAG_W-1:0]                  divisor;
        logic [LIM_W-1:0]                  lim;
    } mag_bus_t;

    // Scaled magnitudes waiting for the division.
    typedef struct packed {
        logic [NUM_WHEELS-1:0]             neg;
        logic [NUM_WHEELS-1:0][PROD_W-1:0] prod;
        logic [MAG_W-1:0]                  divisor;
    } prod_bus_t;

    // Quotient magnitudes with their signs.
    typedef struct packed {
        logic [NUM_WHEELS-1:0]             neg;
        logic [NUM_WHEELS-1:0][QUO_W-1:0]  quo;
    } quo_bus_t;

    // Absolute value of the limit register, clamped to full scale.
    function automatic logic [LIM_W-1:0] clamp_limit(input logic signed [CMD_W-1:0] value);
        logic [CMD_W-1:0] abs_val;
        abs_val = value[CMD_W-1] ? CMD_W'(-value) : CMD_W'(value);
        if (abs_val > CMD_W'(FULL_SCALE)) begin
            return LIM_W'(FULL_SCALE);
        end
        return abs_val[LIM_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/mwm_front.sv]
// Front end of the mixer: forms the four wheel sums, their magnitudes and the divisor.
// Two register stages; depends on mwm_pkg.
`default_nettype none

module mwm_front
    import mwm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic signed [CMD_W-1:0] strafe_cmd,
    input  wire logic signed [CMD_W-1:0] forward_cmd,
    input  wire logic signed [CMD_W-1:0] rotate_cmd,
    input  wire logic [LIM_W-1:0]        lim,
    output logic                         out_valid,
    output mag_bus_t                     out_bus
);

    logic signed [SUM_W-1:0] x_ext;
    logic signed [SUM_W-1:0] y_ext;
    logic signed [SUM_W-1:0] yaw_ext;
    logic signed [SUM_W-1:0] sum_next [NUM_WHEELS];
    logic signed [SUM_W-1:0] sum_reg  [NUM_WHEELS];
    logic [LIM_W-1:0]        lim_reg;
    logic                    valid_a_reg;
    logic                    valid_b_reg;
    mag_bus_t                bus_next;
    mag_bus_t                bus_reg;

    // Stage A: sign-extend the commands and form the wheel sums.
    always_comb
    begin
        x_ext   = SUM_W'(strafe_cmd);
        y_ext   = SUM_W'(forward_cmd);
        yaw_ext = SUM_W'(rotate_cmd);
        sum_next[WHEEL_FL] = x_ext - y_ext - yaw_ext;
        sum_next[WHEEL_FR] = x_ext + y_ext - yaw_ext;
        sum_next[WHEEL_RL] = x_ext - y_ext + yaw_ext;
        sum_next[WHEEL_RR] = x_ext + y_ext + yaw_ext;
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        lim_reg <= lim;
    end

    // Stage B: magnitudes, signs, and the largest magnitude floored at full scale.
    always_comb
    begin
        bus_next.divisor = MAG_W'(FULL_SCALE);
        bus_next.lim     = lim_reg;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            bus_next.neg[i] = sum_reg[i][SUM_W-1];
            bus_next.mag[i] = sum_reg[i][SUM_W-1] ? MAG_W'(-sum_reg[i]) : MAG_W'(sum_reg[i]);
            if (bus_next.mag[i] > bus_next.divisor) begin
                bus_next.divisor = bus_next.mag[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bus_reg <= bus_next;
    end

    // Valid bits follow the data through both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_bus   = bus_reg;

endmodule

`default_nettype wire

[rtl/mwm_scale.sv]
// Scaling stage of the mixer: multiplies each sum magnitude by the clamped limit.
// One register stage; depends on mwm_pkg.
`default_nettype none

module mwm_scale
    import mwm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire mag_bus_t in_bus,
    output logic          out_valid,
    output prod_bus_t     out_bus
);

    prod_bus_t bus_next;
    prod_bus_t bus_reg;
    logic      valid_reg;

    // One narrow multiplier per wheel.
    always_comb
    begin
        bus_next.neg     = in_bus.neg;
        bus_next.divisor = in_bus.divisor;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            bus_next.prod[i] = PROD_W'(in_bus.mag[i]) * PROD_W'(in_bus.lim);
        end
    end

    always_ff @(posedge clk)
    begin
        bus_reg <= bus_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_bus   = bus_reg;

endmodule

`default_nettype wire

[rtl/mwm_divider.sv]
// Pipelined restoring divider: one quotient bit per stage for all four wheels.
// QUO_W register stages; depends on mwm_pkg.
`default_nettype none

module mwm_divider
    import mwm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire prod_bus_t in_bus,
    output logic           out_valid,
    output quo_bus_t       out_bus
);

    typedef struct packed {
        logic [NUM_WHEELS-1:0]             neg;
        logic [NUM_WHEELS-1:0][PROD_W-1:0] rem;
        logic [NUM_WHEELS-1:0][QUO_W-1:0]  quo;
        logic [MAG_W-1:0]                  divisor;
    } div_bus_t;

    div_bus_t          stage_in   [QUO_W];
    div_bus_t          stage_next [QUO_W];
    div_bus_t          stage_reg  [QUO_W];
    logic [QUO_W-1:0]  valid_reg;

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        localparam int unsigned BIT = QUO_W - 1 - s;

        logic [PROD_W:0] shifted_div;

        // The first stage starts from the full product with an empty quotient.
        if (s == 0)
        begin : g_first
            assign stage_in[s] = '{neg: in_bus.neg, rem: in_bus.prod, quo: '0,
                                   divisor: in_bus.divisor};
        end
        else
        begin : g_link
            assign stage_in[s] = stage_reg[s-1];
        end

        // Trial subtraction of the divisor shifted to this quotient bit.
        always_comb
        begin
            shifted_div   = (PROD_W+1)'(stage_in[s].divisor) << BIT;
            stage_next[s] = stage_in[s];
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                if ({1'b0, stage_in[s].rem[i]} >= shifted_div) begin
                    stage_next[s].rem[i]      = PROD_W'({1'b0, stage_in[s].rem[i]} - shifted_div);
                    stage_next[s].quo[i][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[s] <= stage_next[s];
        end
    end

    // Valid bits shift alongside the stage data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= {valid_reg[QUO_W-2:0], in_valid};
        end
    end

    assign out_valid   = valid_reg[QUO_W-1];
    assign out_bus.neg = stage_reg[QUO_W-1].neg;
    assign out_bus.quo = stage_reg[QUO_W-1].quo;

`ifndef SYNTHESIS
    // After the last bit every remainder must be below the divisor.
    property p_rem_below_div(int unsigned lane);
        @(posedge clk) disable iff (!rst_n)
        valid_reg[QUO_W-1] |->
            (stage_reg[QUO_W-1].rem[lane] < PROD_W'(stage_reg[QUO_W-1].divisor));
    endproperty

    a_rem_fl: assert property (p_rem_below_div(WHEEL_FL))
        else $error("front left remainder not below divisor");
    a_rem_rr: assert property (p_rem_below_div(WHEEL_RR))
        else $error("rear right remainder not below divisor");
`endif

endmodule

`default_nettype wire

[rtl/mecanum_wheel_mixer_core.sv]
// Mecanum wheel mixer: an accepted start passes the front, scale, divider and output registers to the done strobe.
// Throughput is one request per cycle; the 7-stage divider pipeline sets the depth.
// busy is always low and cfg_ready always high; the receiver cannot stall results.
// Reset clears every pipeline valid bit and sets the duty limit to 100.
// Depends on mwm_pkg, mwm_front, mwm_scale and mwm_divider.
`default_nettype none

module mecanum_wheel_mixer_core
    import mwm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic signed [CMD_W-1:0] strafe_cmd,
    input  wire logic signed [CMD_W-1:0] forward_cmd,
    input  wire logic signed [CMD_W-1:0] rotate_cmd,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic signed [CMD_W-1:0] duty_limit,
    output logic                         done,
    output logic signed [CMD_W-1:0]      front_left_duty,
    output logic signed [CMD_W-1:0]      front_right_duty,
    output logic signed [CMD_W-1:0]      rear_left_duty,
    output logic signed [CMD_W-1:0]      rear_right_duty
);

    logic                               accept;
    logic [LIM_W-1:0]                   limit_reg;
    logic                               front_valid;
    mag_bus_t                           front_bus;
    logic                               scale_valid;
    prod_bus_t                          scale_bus;
    logic                               div_valid;
    quo_bus_t                           div_bus;
    logic [NUM_WHEELS-1:0][CMD_W-1:0]   duty_next;
    logic [NUM_WHEELS-1:0][CMD_W-1:0]   duty_reg;
    logic                               done_reg;

    // The pipeline takes a request every cycle.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Limit register holds the clamped magnitude.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            limit_reg <= LIM_W'(FULL_SCALE);
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= clamp_limit(duty_limit);
        end
    end

    mwm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .strafe_cmd  (strafe_cmd),
        .forward_cmd (forward_cmd),
        .rotate_cmd  (rotate_cmd),
        .lim         (limit_reg),
        .out_valid   (front_valid),
        .out_bus     (front_bus)
    );

    mwm_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_bus    (front_bus),
        .out_valid (scale_valid),
        .out_bus   (scale_bus)
    );

    mwm_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scale_valid),
        .in_bus    (scale_bus),
        .out_valid (div_valid),
        .out_bus   (div_bus)
    );

    // Output stage: restore the sign of each quotient.
    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            duty_next[i] = div_bus.neg[i] ? CMD_W'(-CMD_W'(div_bus.quo[i]))
                                          : CMD_W'(div_bus.quo[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        duty_reg <= duty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= div_valid;
        end
    end

    assign done             = done_reg;
    assign front_left_duty  = $signed(duty_reg[WHEEL_FL]);
    assign front_right_duty = $signed(duty_reg[WHEEL_FR]);
    assign rear_left_duty   = $signed(duty_reg[WHEEL_RL]);
    assign rear_right_duty  = $signed(duty_reg[WHEEL_RR]);

`ifndef SYNTHESIS
    // Every accepted request produces its strobe after the full pipeline depth.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##11 done)
        else $error("done strobe missing after accepted request");

    // A wheel duty never exceeds full scale in magnitude.
    a_fl_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (front_left_duty >= -8'sd100) && (front_left_duty <= 8'sd100))
        else $error("front left duty out of range");

    a_rr_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rear_right_duty >= -8'sd100) && (rear_right_duty <= 8'sd100))
        else $error("rear right duty out of range");
`endif

endmodule

`default_nettype wire
